@@ hw/rtl/lsrc_pkg.sv @@
`default_nettype none
package lsrc_pkg;

    localparam int C_MAX_PASSES = 16;
    localparam int C_COORD_BITS = 32;
    localparam int C_SNAP_TOL   = 7;

    // Outcode bits
    localparam logic [3:0] CODE_L = 4'b0001;
    localparam logic [3:0] CODE_R = 4'b0010;
    localparam logic [3:0] CODE_T = 4'b0100;
    localparam logic [3:0] CODE_B = 4'b1000;

    typedef enum logic [1:0] {
        CFG_LEFT   = 2'd0,
        CFG_RIGHT  = 2'd1,
        CFG_TOP    = 2'd2,
        CFG_BOTTOM = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
    } t_in_item;

    typedef struct packed {
        logic               visible;
        logic signed [31:0] out_start_x;
        logic signed [31:0] out_start_y;
        logic signed [31:0] out_end_x;
        logic signed [31:0] out_end_y;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CODE,
        ST_SETUP,
        ST_WAIT
    } t_back_state;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_DONE
    } t_md_state;

    // Saturate a signed value to a signed field of the given width
    function automatic logic signed [63:0] sat64(logic signed [63:0] v, int unsigned bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/lsrc_fifo.sv @@
`default_nettype none
module lsrc_fifo
    import lsrc_pkg::*;
#(
    parameter int DW = 4 * C_COORD_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_data,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output logic [DW-1:0]      o_data
);

    logic [DW-1:0] r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= ~r_wr;
            end
            if (i_pop && !o_empty) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/lsrc_front.sv @@
`default_nettype none
module lsrc_front
    import lsrc_pkg::*;
#(
    parameter int COORD_BITS = C_COORD_BITS,
    parameter int SNAP_TOL   = C_SNAP_TOL
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    output logic                              o_full,
    input  wire t_in_item                     i_item,
    input  wire logic signed [COORD_BITS-1:0] i_left,
    input  wire logic signed [COORD_BITS-1:0] i_right,
    input  wire logic signed [COORD_BITS-1:0] i_top,
    input  wire logic signed [COORD_BITS-1:0] i_bottom,
    input  wire logic                         i_q_full,
    output logic                              o_q_push,
    output logic [4*COORD_BITS-1:0]           o_q_data
);

    localparam int W = COORD_BITS;
    localparam logic signed [W:0] TOL = (W + 1)'(SNAP_TOL);

    logic                r_valid;
    logic signed [W-1:0] r_x1, r_y1, r_x2, r_y2;
    logic                accept;

    function automatic logic signed [W-1:0] sat_in(logic signed [31:0] v);
        logic signed [63:0] s;
        s = sat64(64'(v), W);
        return s[W-1:0];
    endfunction

    function automatic logic near(logic signed [W-1:0] v, logic signed [W-1:0] e);
        logic signed [W:0] d;
        d = (W + 1)'(v) - (W + 1)'(e);
        return (d < TOL) && (d > -TOL);
    endfunction

    // Low edge first, then high edge sees the already snapped value
    function automatic logic signed [W-1:0] snap(logic signed [W-1:0] v,
                                                 logic signed [W-1:0] lo,
                                                 logic signed [W-1:0] hi);
        logic signed [W-1:0] t;
        t = near(v, lo) ? lo : v;
        return near(t, hi) ? hi : t;
    endfunction

    assign o_full   = r_valid && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_q_data = {snap(r_x1, i_left, i_right), snap(r_y1, i_top, i_bottom),
                       snap(r_x2, i_left, i_right), snap(r_y2, i_top, i_bottom)};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x1 <= sat_in(i_item.start_x);
            r_y1 <= sat_in(i_item.start_y);
            r_x2 <= sat_in(i_item.end_x);
            r_y2 <= sat_in(i_item.end_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/lsrc_muldiv.sv @@
`default_nettype none
module lsrc_muldiv
    import lsrc_pkg::*;
#(
    parameter int MW = C_COORD_BITS + 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [MW-1:0] i_a,
    input  wire logic [MW-1:0] i_b,
    input  wire logic [MW-1:0] i_d,
    output logic               o_done,
    output logic [MW-1:0]      o_q
);

    localparam int PW = 2 * MW;
    localparam int CW = $clog2(PW);
    localparam logic [MW-1:0] QMAX = MW'(1) << (MW - 1);

    t_md_state     r_state, n_state;
    logic [MW-1:0] r_a;
    logic [PW-1:0] r_bsh;
    logic [PW-1:0] r_acc;
    logic [CW-1:0] r_cnt;
    logic [MW-1:0] r_rem;
    logic [MW-1:0] r_d;
    logic [MW-1:0] r_q;
    logic          r_ovf;
    logic [MW:0]   trial;
    logic          qbit;

    assign trial = {r_rem, r_acc[PW-1]};
    assign qbit  = (trial >= {1'b0, r_d});

    always_comb begin
        n_state = r_state;
        case (r_state)
            MD_IDLE: if (i_start) n_state = MD_MUL;
            MD_MUL:  if (r_cnt == CW'(MW - 1)) n_state = MD_DIV;
            MD_DIV:  if (r_cnt == CW'(PW - 1)) n_state = MD_DONE;
            MD_DONE: n_state = MD_IDLE;
            default: n_state = MD_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == MD_DONE);
        o_q    = (r_ovf || r_q[MW-1]) ? QMAX : r_q;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            MD_IDLE: begin
                r_a   <= i_a;
                r_bsh <= PW'(i_b);
                r_d   <= i_d;
                r_acc <= '0;
                r_cnt <= '0;
            end
            MD_MUL: begin
                if (r_a[0]) begin
                    r_acc <= r_acc + r_bsh;
                end
                r_bsh <= r_bsh << 1;
                r_a   <= r_a >> 1;
                r_cnt <= (r_cnt == CW'(MW - 1)) ? '0 : r_cnt + CW'(1);
                r_rem <= '0;
                r_q   <= '0;
                r_ovf <= 1'b0;
            end
            MD_DIV: begin
                r_acc <= r_acc << 1;
                r_rem <= qbit ? MW'(trial - {1'b0, r_d}) : trial[MW-1:0];
                r_q   <= {r_q[MW-2:0], qbit};
                r_ovf <= r_ovf | r_q[MW-1];
                r_cnt <= r_cnt + CW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/lsrc_back.sv @@
`default_nettype none
module lsrc_back
    import lsrc_pkg::*;
#(
    parameter int COORD_BITS = C_COORD_BITS,
    parameter int MAX_PASSES = C_MAX_PASSES
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_empty,
    input  wire logic [4*COORD_BITS-1:0]      i_q_data,
    output logic                              o_q_pop,
    input  wire logic signed [COORD_BITS-1:0] i_left,
    input  wire logic signed [COORD_BITS-1:0] i_right,
    input  wire logic signed [COORD_BITS-1:0] i_top,
    input  wire logic signed [COORD_BITS-1:0] i_bottom,
    input  wire logic                         i_pop,
    output logic                              o_empty,
    output t_out_item                         o_item
);

    localparam int W   = COORD_BITS;
    localparam int MW  = W + 1;
    localparam int PCW = $clog2(MAX_PASSES + 1);

    t_back_state         r_state, n_state;
    logic signed [W-1:0] r_x1, r_y1, r_x2, r_y2;
    logic [PCW-1:0]      r_pass;
    logic [3:0]          r_c;
    logic                r_first;
    logic                r_isx;
    logic signed [W-1:0] r_edge;
    logic signed [W-1:0] r_b1;
    logic                r_neg;
    t_out_item           r_res;
    logic                r_res_valid;
    logic                md_start;
    logic                md_done;

    logic [3:0]          c1, c2;
    logic                isx;
    logic signed [W-1:0] edge_v, a1, b1, a2, b2;
    logic signed [W:0]   n1, n2, den;
    logic                trivial;
    logic [MW-1:0]       md_q;
    logic signed [W+1:0] sum;
    logic signed [W-1:0] b_wait, new_b;
    logic                commit;
    logic                sel_isx;
    logic signed [W-1:0] sel_edge;

    function automatic logic [3:0] outcode(logic signed [W-1:0] x, logic signed [W-1:0] y);
        logic [3:0] c;
        c = '0;
        if (x < i_left) c |= CODE_L;
        else if (x > i_right) c |= CODE_R;
        if (y < i_top) c |= CODE_T;
        else if (y > i_bottom) c |= CODE_B;
        return c;
    endfunction

    function automatic logic [MW-1:0] mag(logic signed [W:0] v);
        return v[W] ? MW'(-v) : MW'(v);
    endfunction

    function automatic logic [31:0] to_out(logic signed [W-1:0] v);
        logic signed [63:0] s;
        s = sat64(64'(v), 32);
        return s[31:0];
    endfunction

    assign c1 = outcode(r_x1, r_y1);
    assign c2 = outcode(r_x2, r_y2);

    // Edge selection: left, right, top, bottom in that order
    always_comb begin
        isx    = 1'b1;
        edge_v = i_left;
        if ((r_c & CODE_L) != 4'd0) begin
            edge_v = i_left;
        end else if ((r_c & CODE_R) != 4'd0) begin
            edge_v = i_right;
        end else if ((r_c & CODE_T) != 4'd0) begin
            isx    = 1'b0;
            edge_v = i_top;
        end else begin
            isx    = 1'b0;
            edge_v = i_bottom;
        end
        a1  = isx ? r_x1 : r_y1;
        b1  = isx ? r_y1 : r_x1;
        a2  = isx ? r_x2 : r_y2;
        b2  = isx ? r_y2 : r_x2;
        n1  = (W + 1)'(edge_v) - (W + 1)'(a1);
        n2  = (W + 1)'(b2) - (W + 1)'(b1);
        den = (W + 1)'(a2) - (W + 1)'(a1);
        trivial = (a1 == a2) || (n1 == '0) || (n2 == '0);
    end

    // Offset the fixed coordinate by the quotient and saturate
    always_comb begin
        sum = r_neg ? (W + 2)'(r_b1) - (W + 2)'({1'b0, md_q})
                    : (W + 2)'(r_b1) + (W + 2)'({1'b0, md_q});
        if (sum > $signed((W + 2)'({1'b0, {(W - 1){1'b1}}}))) begin
            b_wait = {1'b0, {(W - 1){1'b1}}};
        end else if (sum < -$signed((W + 2)'({1'b1, {(W - 1){1'b0}}}))) begin
            b_wait = {1'b1, {(W - 1){1'b0}}};
        end else begin
            b_wait = sum[W-1:0];
        end
        new_b    = (r_state == ST_SETUP) ? b1 : b_wait;
        sel_isx  = (r_state == ST_SETUP) ? isx : r_isx;
        sel_edge = (r_state == ST_SETUP) ? edge_v : r_edge;
        commit   = ((r_state == ST_SETUP) && trivial) || ((r_state == ST_WAIT) && md_done);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (!r_res_valid && !i_q_empty) n_state = ST_CODE;
            ST_CODE: begin
                if ((r_pass == PCW'(MAX_PASSES)) || ((c1 | c2) == 4'd0)
                        || ((c1 & c2) != 4'd0)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: n_state = trivial ? ST_CODE : ST_WAIT;
            ST_WAIT:  if (md_done) n_state = ST_CODE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = (r_state == ST_IDLE) && !r_res_valid && !i_q_empty;
        md_start = (r_state == ST_SETUP) && !trivial;
        o_empty  = !r_res_valid;
        o_item   = r_res;
    end

    lsrc_muldiv #(
        .MW (MW)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (md_start),
        .i_a     (mag(n1)),
        .i_b     (mag(n2)),
        .i_d     (mag(den)),
        .o_done  (md_done),
        .o_q     (md_q)
    );

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_x1   <= $signed(i_q_data[4*W-1:3*W]);
                r_y1   <= $signed(i_q_data[3*W-1:2*W]);
                r_x2   <= $signed(i_q_data[2*W-1:W]);
                r_y2   <= $signed(i_q_data[W-1:0]);
                r_pass <= '0;
            end
            ST_CODE: begin
                r_c     <= (c1 != 4'd0) ? c1 : c2;
                r_first <= (c1 != 4'd0);
                if ((r_pass != PCW'(MAX_PASSES)) && ((c1 | c2) == 4'd0)) begin
                    r_res.visible     <= 1'b1;
                    r_res.out_start_x <= to_out(r_x1);
                    r_res.out_start_y <= to_out(r_y1);
                    r_res.out_end_x   <= to_out(r_x2);
                    r_res.out_end_y   <= to_out(r_y2);
                end else begin
                    r_res <= '0;
                end
            end
            ST_SETUP: begin
                r_isx  <= isx;
                r_edge <= edge_v;
                r_b1   <= b1;
                r_neg  <= (n1[W] ^ n2[W]) ^ den[W];
            end
            default: begin
            end
        endcase
        if (commit) begin
            r_pass <= r_pass + PCW'(1);
            if (r_first) begin
                r_x1 <= sel_isx ? sel_edge : new_b;
                r_y1 <= sel_isx ? new_b : sel_edge;
            end else begin
                r_x2 <= sel_isx ? sel_edge : new_b;
                r_y2 <= sel_isx ? new_b : sel_edge;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_CODE) && (n_state == ST_IDLE)) begin
                r_res_valid <= 1'b1;
            end else if (i_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/line_segment_rect_clipper.sv @@
// Line segment rectangle clipper. Push one segment (two endpoints, signed
// Q16.16) and pop one result: visible plus the clipped endpoints, or all
// zero when the segment is rejected. Endpoint coordinates less than SNAP_TOL
// LSBs from an edge are snapped onto it first, then Cohen-Sutherland passes
// move one outside endpoint per pass, trying left, right, top, bottom; a
// segment not settled after MAX_PASSES passes is rejected. A segment goes
// through the front end, queue and clip engine; a pass that needs an
// intersection runs through the shared bit-serial multiply/divide unit.
// A two-entry queue behind the snapping front end takes new segments while
// the clip engine works, and the finished result waits in an output
// register. Write the rectangle registers only while the block is idle;
// configuration writes are always ready.
`default_nettype none
module line_segment_rect_clipper
    import lsrc_pkg::*;
#(
    parameter int MAX_PASSES = C_MAX_PASSES,
    parameter int COORD_BITS = C_COORD_BITS,
    parameter int SNAP_TOL   = C_SNAP_TOL
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire t_in_item   i_in_item,
    output logic            empty,
    input  wire logic       pop,
    output t_out_item       o_out_item,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire t_cfg_index i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int W = COORD_BITS;

    // Rectangle registers, held saturated to the coordinate width
    logic signed [W-1:0] r_left, r_right, r_top, r_bottom;
    logic signed [W-1:0] cfg_val;
    logic signed [63:0]  cfg_sat;

    logic                q_push, q_pop, q_full, q_empty;
    logic [4*W-1:0]      q_wdata, q_rdata;

    assign o_cfg_ready = 1'b1;
    assign cfg_sat     = sat64(64'($signed(i_cfg_data)), W);
    assign cfg_val     = cfg_sat[W-1:0];

    // Update the addressed edge on each configuration transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_right  <= '0;
            r_top    <= '0;
            r_bottom <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LEFT:   r_left   <= cfg_val;
                CFG_RIGHT:  r_right  <= cfg_val;
                CFG_TOP:    r_top    <= cfg_val;
                CFG_BOTTOM: r_bottom <= cfg_val;
                default: begin
                end
            endcase
        end
    end

    // Front end: hold the pushed segment, snap it, hand it to the queue
    lsrc_front #(
        .COORD_BITS (W),
        .SNAP_TOL   (SNAP_TOL)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_item   (i_in_item),
        .i_left   (r_left),
        .i_right  (r_right),
        .i_top    (r_top),
        .i_bottom (r_bottom),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    // Decouple front end and clip engine
    lsrc_fifo #(
        .DW (4 * W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    // Clip engine: outcode passes, edge intersections, result register
    lsrc_back #(
        .COORD_BITS (W),
        .MAX_PASSES (MAX_PASSES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .i_left    (r_left),
        .i_right   (r_right),
        .i_top     (r_top),
        .i_bottom  (r_bottom),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_out_item)
    );

    // A rejected result carries zero coordinates
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_item.visible) |-> (o_out_item.out_start_x == 0
            && o_out_item.out_start_y == 0 && o_out_item.out_end_x == 0
            && o_out_item.out_end_y == 0))
        else $error("rejected result with nonzero coordinates");

    // The front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue overflow");

    // The clip engine only takes a segment that is there
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue underflow");

endmodule
`default_nettype wire

@@ verif/line_segment_rect_clipper_tb.sv @@
`default_nettype none
module line_segment_rect_clipper_tb;
    import lsrc_pkg::*;

    // Scoreboard: holds its own copy of the clip rectangle, predicts each
    // clipped segment when a segment transfer is accepted, and compares
    // every popped result against the oldest prediction.
    class clip_scoreboard;
        longint    rect_left, rect_right, rect_top, rect_bottom;
        t_out_item clipped_q[$];
        int        mismatches;

        function new();
            rect_left = 0;
            rect_right = 0;
            rect_top = 0;
            rect_bottom = 0;
            mismatches = 0;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) begin
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function logic [63:0] mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // Coordinate b on the segment where coordinate a reaches the edge.
        function longint cross_at(longint a1, longint b1, longint a2, longint b2,
                                  longint edge_pos);
            longint       n1, n2, den, q;
            bit           neg;
            logic [127:0] prod, quot;
            if (a1 == a2) begin
                return b1;
            end
            n1 = edge_pos - a1;
            n2 = b2 - b1;
            den = a2 - a1;
            neg = ((n1 < 0) != (n2 < 0)) != (den < 0);
            if (n1 == 0 || n2 == 0) begin
                return b1;
            end
            prod = {64'd0, mag(n1)} * {64'd0, mag(n2)};
            quot = prod / {64'd0, mag(den)};
            // limit the quotient so the add below cannot wrap
            if (quot > (128'd1 << 62)) begin
                quot = 128'd1 << 62;
            end
            q = longint'(quot[63:0]);
            return sat32(neg ? b1 - q : b1 + q);
        endfunction

        function logic [3:0] region(longint x, longint y);
            logic [3:0] c;
            c = '0;
            if (x < rect_left) begin
                c |= CODE_L;
            end else if (x > rect_right) begin
                c |= CODE_R;
            end
            if (y < rect_top) begin
                c |= CODE_T;
            end else if (y > rect_bottom) begin
                c |= CODE_B;
            end
            return c;
        endfunction

        // Snap in order left, right, top, bottom; later tests see snapped values.
        function void snap_point(inout longint x, inout longint y);
            if (mag(x - rect_left) < C_SNAP_TOL) x = rect_left;
            if (mag(x - rect_right) < C_SNAP_TOL) x = rect_right;
            if (mag(y - rect_top) < C_SNAP_TOL) y = rect_top;
            if (mag(y - rect_bottom) < C_SNAP_TOL) y = rect_bottom;
        endfunction

        function void note_segment(t_in_item seg);
            longint     x1, y1, x2, y2, nx, ny;
            logic [3:0] c1, c2, c;
            bit         accepted;
            t_out_item  res;
            x1 = seg.start_x;
            y1 = seg.start_y;
            x2 = seg.end_x;
            y2 = seg.end_y;
            accepted = 0;
            snap_point(x1, y1);
            snap_point(x2, y2);
            c1 = region(x1, y1);
            c2 = region(x2, y2);
            for (int p = 0; p < C_MAX_PASSES; p++) begin
                if ((c1 | c2) == 0) begin
                    accepted = 1;
                    break;
                end
                if ((c1 & c2) != 0) break;
                c = (c1 != 0) ? c1 : c2;
                if (c & CODE_L) begin
                    nx = rect_left;
                    ny = cross_at(x1, y1, x2, y2, rect_left);
                end else if (c & CODE_R) begin
                    nx = rect_right;
                    ny = cross_at(x1, y1, x2, y2, rect_right);
                end else if (c & CODE_T) begin
                    ny = rect_top;
                    nx = cross_at(y1, x1, y2, x2, rect_top);
                end else begin
                    ny = rect_bottom;
                    nx = cross_at(y1, x1, y2, x2, rect_bottom);
                end
                if (c == c1) begin
                    x1 = nx;
                    y1 = ny;
                    c1 = region(x1, y1);
                end else begin
                    x2 = nx;
                    y2 = ny;
                    c2 = region(x2, y2);
                end
            end
            res = '0;
            if (accepted) begin
                res.visible = 1'b1;
                res.out_start_x = sat32(x1);
                res.out_start_y = sat32(y1);
                res.out_end_x = sat32(x2);
                res.out_end_y = sat32(y2);
            end
            clipped_q.push_back(res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (clipped_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = clipped_q.pop_front();
            if (got.visible !== want.visible || got.out_start_x !== want.out_start_x ||
                got.out_start_y !== want.out_start_y || got.out_end_x !== want.out_end_x ||
                got.out_end_y !== want.out_end_y) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected vis=%0d (%0d,%0d)-(%0d,%0d)",
                             want.visible, want.out_start_x, want.out_start_y,
                             want.out_end_x, want.out_end_y);
                    $display("          actual   vis=%0d (%0d,%0d)-(%0d,%0d)",
                             got.visible, got.out_start_x, got.out_start_y,
                             got.out_end_x, got.out_end_y);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_item    i_in_item;
    logic        empty;
    logic        pop;
    t_out_item   o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    t_cfg_index  i_cfg_index;
    logic [31:0] i_cfg_data;

    clip_scoreboard sb;
    int idle_pct;   // sender idle chance in percent
    int stall_pct;  // receiver stall chance in percent

    line_segment_rect_clipper uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_in_item(i_in_item),
        .empty(empty),
        .pop(pop),
        .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        push = 1'b0;
        pop = 1'b0;
        i_in_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_LEFT;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        sb = new();
    end

    // Note accepted segment transfers and check accepted result transfers.
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) sb.note_segment(i_in_item);
        if (i_rst_n && pop && !empty) sb.check_result(o_out_item);
    end

    // Receiver: stall at random according to the current phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Hold the segment until it is taken; leave push high for the next one.
    task automatic send_segment(logic [31:0] sx, logic [31:0] sy,
                                logic [31:0] ex, logic [31:0] ey);
        if ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in_item <= '{sx, sy, ex, ey};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // Drop push and wait until every predicted result has been popped.
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.clipped_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // Leave valid high; the caller drops it after the last write.
    task automatic write_edge(t_cfg_index idx, logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_LEFT: sb.rect_left = longint'($signed(value));
            CFG_RIGHT: sb.rect_right = longint'($signed(value));
            CFG_TOP: sb.rect_top = longint'($signed(value));
            default: sb.rect_bottom = longint'($signed(value));
        endcase
    endtask

    task automatic set_rect(logic [31:0] l, logic [31:0] r, logic [31:0] t, logic [31:0] b);
        write_edge(CFG_LEFT, l);
        write_edge(CFG_RIGHT, r);
        write_edge(CFG_TOP, t);
        write_edge(CFG_BOTTOM, b);
        i_cfg_valid <= 1'b0;
    endtask

    // Coordinate near the span [lo, hi]: inside, near an edge, or anywhere.
    function automatic logic [31:0] pick_coord(longint lo, longint hi);
        longint span;
        span = (hi > lo) ? hi - lo : lo - hi;
        case ($urandom_range(9))
            0, 1: return $urandom;
            2, 3: return 32'(lo + $signed($urandom_range(20)) - 10);
            4, 5: return 32'(hi + $signed($urandom_range(20)) - 10);
            default: return 32'(lo - span + longint'($urandom_range(32'hFFFF_FFFF)) %
                                (3 * span + 1));
        endcase
    endfunction

    task automatic random_segments(int count);
        logic [31:0] sx, sy, ex, ey;
        for (int k = 0; k < count; k++) begin
            sx = pick_coord(sb.rect_left, sb.rect_right);
            sy = pick_coord(sb.rect_top, sb.rect_bottom);
            ex = pick_coord(sb.rect_left, sb.rect_right);
            ey = pick_coord(sb.rect_top, sb.rect_bottom);
            // make some segments parallel to an axis
            if ($urandom_range(9) == 0) ex = sx;
            if ($urandom_range(9) == 0) ey = sy;
            send_segment(sx, sy, ex, ey);
        end
    endtask

    localparam logic [31:0] MAXC = 32'h7FFF_FFFF;
    localparam logic [31:0] MINC = 32'h8000_0000;

    initial begin
        logic [31:0] a, b;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Rectangle at reset is a single point at the origin.
        send_segment(0, 0, 0, 0);
        send_segment(-3, 5, 6, -6);
        send_segment(MINC, MINC, MAXC, MAXC);
        drain();

        // Directed: rectangle [-100,100] x [-50,50] in Q16.16.
        set_rect(-32'sd100 <<< 16, 32'sd100 <<< 16, -32'sd50 <<< 16, 32'sd50 <<< 16);
        send_segment(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 32'hFFFE_0000);
        send_segment(-32'sd200 <<< 16, 0, -32'sd150 <<< 16, 10 <<< 16);
        send_segment(-32'sd200 <<< 16, 0, 32'sd200 <<< 16, 32'sd30 <<< 16);
        send_segment(0, -32'sd90 <<< 16, 32'sd10 <<< 16, 32'sd90 <<< 16);
        send_segment(-32'sd300 <<< 16, -32'sd300 <<< 16, 32'sd300 <<< 16, 32'sd300 <<< 16);
        send_segment(5 <<< 16, -32'sd80 <<< 16, 5 <<< 16, 32'sd80 <<< 16);
        send_segment(-32'sd150 <<< 16, 7 <<< 16, 32'sd150 <<< 16, 7 <<< 16);
        send_segment((-32'sd100 <<< 16) - 6, 0, (32'sd100 <<< 16) + 6, 3);
        send_segment((-32'sd100 <<< 16) - 7, 0, (32'sd100 <<< 16) + 7, 3);
        send_segment(0, (-32'sd50 <<< 16) + 6, 1, (32'sd50 <<< 16) - 6);
        send_segment(MINC, MINC, MAXC, MAXC);
        send_segment(MAXC, MINC, MINC, MAXC);
        send_segment(MAXC, 0, MINC, 0);
        send_segment(-32'sd120 <<< 16, 32'sd60 <<< 16, 32'sd120 <<< 16, -32'sd60 <<< 16);
        send_segment(-32'sd110 <<< 16, 32'sd40 <<< 16, -32'sd90 <<< 16, 32'sd70 <<< 16);
        drain();

        // Inverted rectangle: every point lies outside some edge.
        set_rect(32'sd50 <<< 16, -32'sd50 <<< 16, 32'sd20 <<< 16, -32'sd20 <<< 16);
        send_segment(0, 0, 1 <<< 16, 1 <<< 16);
        send_segment(-32'sd100 <<< 16, 0, 32'sd100 <<< 16, 0);
        send_segment(0, -32'sd100 <<< 16, 32'sd3 <<< 16, 32'sd100 <<< 16);
        send_segment(MINC, MAXC, MAXC, MINC);
        drain();

        // Random phases, each with its own rectangle and one of four idling patterns.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_rect(MINC, MAXC, MINC, MAXC);
                1: set_rect(MAXC, MAXC, MINC, MINC);
                2: set_rect(32'hFFF0_0000, 32'h0010_0000, 32'hFFF8_0000, 32'h0008_0000);
                default: begin
                    a = $urandom;
                    b = $urandom;
                    if ($urandom_range(4) != 0 && $signed(a) > $signed(b)) begin
                        set_rect(b, a, $signed(b) >>> 1, $signed(a) >>> 1);
                    end else begin
                        set_rect(a, b, $urandom, $urandom);
                    end
                end
            endcase
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 32; stall_pct = 32; end
            endcase
            random_segments(145);
            drain();
        end

        if (sb.mismatches == 0 && sb.clipped_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hold a hard limit well past the slowest legal run.
    initial begin
        #200000000;
        $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
